// ===== rtl/assert_macros.svh =====
// Assertion macros used by the tone generator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while reset is released.
`define DSTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tone generator assertion failed");

// Next-cycle implication, checked only while reset is released.
`define DSTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tone generator assertion failed");

`endif

// ===== rtl/dstg_pkg.sv =====
// Shared types and constants of the decaying sine tone generator.
`default_nettype none
package dstg_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 31;

	localparam logic [CFG_INDEX_W-1:0] REG_ENABLED         = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INCREMENT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TONE_LENGTH     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_GAIN     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ENVELOPE_STEP   = 3'd4;

	localparam logic        RST_ENABLED         = 1'b1;
	localparam logic [30:0] RST_PHASE_INCREMENT = 31'd77906381;
	localparam logic [15:0] RST_TONE_LENGTH     = 16'd3528;
	localparam logic [14:0] RST_VOLUME_GAIN     = 15'd13107;
	localparam logic [16:0] RST_ENVELOPE_STEP   = 17'd19;

	// Envelope value 1.0 in Q16.
	localparam logic [16:0] ENV_ONE = 17'h10000;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_MUL1 = 4'b0100,
		S_MUL2 = 4'b1000
	} state_t;

	typedef struct packed {
		logic accept;
		logic read;
		logic mul1;
		logic load_out;
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/decaying_sine_tone_generator_core.sv =====
// A request passes the table read and both multiplies before its result is valid.
// A new sample request is taken only once the previous one has left the final multiply.
// A result waiting at the output holds back only the final multiply stage.
// Reset (arst_n low) restores register defaults, clears tone state and drops any result.
// The sine table is a constant quarter-wave table, so no fill pass follows reset.
`default_nettype none
module decaying_sine_tone_generator_core #(
	parameter int unsigned PHASE_BITS       = 32,
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned LENGTH_BITS      = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [dstg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [dstg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             start_req,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [15:0]                    sample,
	output logic                                  active,
	output logic                                  last
);
	import dstg_pkg::*;

	`include "assert_macros.svh"

	// Command bundle from the sequencer to the datapath. Each bit enables one
	// stage: taking a tick request and updating the tone state, reading the
	// sine table, the volume multiply, and the envelope multiply that loads
	// the result register.
	cmd_t cmd;

	// The sequencer owns both handshakes. It takes a new request only when
	// idle, walks the read and both multiply states, and waits in the last
	// one only if the previous result has not been taken yet.
	dstg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath holds the configuration registers, the phase accumulator,
	// sample counter and envelope, and the sample pipeline. Tone state is
	// updated on the accept edge, so the next request sees it at once.
	dstg_datapath #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.LENGTH_BITS      (LENGTH_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.start_req (start_req),
		.sample    (sample),
		.active    (active),
		.last      (last)
	);

	// A request keeps the block busy until its result is loaded, so it
	// cannot be followed directly by another one.
	`DSTG_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// The final sample of a tone always belongs to that tone.
	`DSTG_ASSERT_IMP(a_last_is_active, clk, arst_n, out_valid && last, active)
	// Silent ticks carry a zero sample.
	`DSTG_ASSERT_IMP(a_idle_is_silent, clk, arst_n, out_valid && !active, sample == 16'sd0)

endmodule
`default_nettype wire

// ===== rtl/dstg_ctrl.sv =====
// Sequencing state machine of the tone generator.
`default_nettype none
module dstg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output dstg_pkg::cmd_t     cmd
);
	import dstg_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		in_ready     = (state_q == S_IDLE);
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.read     = (state_q == S_READ);
		cmd.mul1     = (state_q == S_MUL1);
		// The result register may be reloaded once its request is gone or leaves now.
		cmd.load_out = (state_q == S_MUL2) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_READ;
			end
			S_READ: state_d = S_MUL1;
			S_MUL1: state_d = S_MUL2;
			S_MUL2: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/dstg_datapath.sv =====
// Datapath of the tone generator: registers, tone state, sine table and scaling.
`default_nettype none
module dstg_datapath #(
	parameter int unsigned PHASE_BITS       = 32,
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned LENGTH_BITS      = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [dstg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [dstg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire dstg_pkg::cmd_t                   cmd,
	input  wire logic                            start_req,
	output logic signed [15:0]                   sample,
	output logic                                 active,
	output logic                                 last
);
	import dstg_pkg::*;

	localparam int unsigned LOG2N  = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned QDEPTH = SINE_TABLE_DEPTH / 4;
	localparam int unsigned JW     = LOG2N - 1;
	localparam int unsigned SW     = (PHASE_BITS > 31) ? PHASE_BITS : 31;
	localparam int unsigned LB     = LENGTH_BITS;

	// sin(x) for x in [0, pi/2], argument and result in Q30.
	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		x2 = (x * x) >> 30;
		t  = 64'd1073741824 - x2 / 64'd110;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
		t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
		return (x * t) >> 30;
	endfunction

	// Quarter wave of the full table: entry j is the magnitude at angle j * 2pi / depth.
	function automatic logic [14:0] qrom_entry(input int unsigned j);
		logic [63:0] x;
		logic [63:0] m;
		x = (64'(4 * j) * 64'd1686629713) >> LOG2N;
		m = (sin_q30(x) * 64'd32767 + 64'd536870912) >> 30;
		if (m > 64'd32767) m = 64'd32767;
		return m[14:0];
	endfunction

	logic [14:0] qrom [0:QDEPTH];

	for (genvar g = 0; g <= QDEPTH; g++) begin : g_qrom
		localparam logic [14:0] ENTRY = qrom_entry(g);
		assign qrom[g] = ENTRY;
	end

	// Configuration registers.
	logic        enabled_q;
	logic [30:0] phase_inc_q;
	logic [15:0] tone_len_q;
	logic [14:0] volume_q;
	logic [16:0] env_step_q;

	// Tone state.
	logic [PHASE_BITS-1:0] phase_q;
	logic [LB-1:0]         index_q;
	logic [16:0]           env_q;
	logic                  tone_active_q;

	// Per-sample pipeline.
	logic [JW-1:0] j_s1;
	logic          neg_s1;
	logic [16:0]   env_s1;
	logic          act_s1;
	logic          fin_s1;
	logic [14:0]   mag_s2;
	logic [29:0]   prod_s3;

	logic signed [15:0] sample_q;
	logic               active_q;
	logic               last_q;

	// Start-adjusted view of the state for the sample being accepted.
	logic [PHASE_BITS-1:0] phase_eff;
	logic [LB-1:0]         index_eff;
	logic [16:0]           env_eff;
	logic                  play;
	logic [LOG2N-1:0]      addr;
	logic [JW-1:0]         j_next;
	logic [LB:0]           index_inc;
	logic [LB:0]           len_ext;
	logic                  fin;
	logic [SW-1:0]         phase_sum;
	logic [46:0]           full_prod;
	logic [15:0]           mag_out;

	always_comb begin
		phase_eff = start_req ? '0 : phase_q;
		index_eff = start_req ? '0 : index_q;
		env_eff   = start_req ? ENV_ONE : env_q;
		play      = enabled_q && (start_req || tone_active_q);
		addr      = phase_eff[PHASE_BITS-1 -: LOG2N];
		if (addr[LOG2N-2]) begin
			j_next = JW'(QDEPTH) - JW'(addr[LOG2N-3:0]);
		end else begin
			j_next = JW'(addr[LOG2N-3:0]);
		end
		index_inc = {1'b0, index_eff} + (LB + 1)'(1);
		len_ext   = {1'b0, LB'(tone_len_q)};
		fin       = (index_inc >= len_ext);
		phase_sum = SW'(phase_eff) + SW'(phase_inc_q);
		full_prod = 47'(prod_s3) * 47'(env_s1);
		mag_out   = full_prod[46:31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q   <= RST_ENABLED;
			phase_inc_q <= RST_PHASE_INCREMENT;
			tone_len_q  <= RST_TONE_LENGTH;
			volume_q    <= RST_VOLUME_GAIN;
			env_step_q  <= RST_ENVELOPE_STEP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLED:         enabled_q   <= cfg_data[0];
				REG_PHASE_INCREMENT: phase_inc_q <= cfg_data[30:0];
				REG_TONE_LENGTH:     tone_len_q  <= cfg_data[15:0];
				REG_VOLUME_GAIN:     volume_q    <= cfg_data[14:0];
				REG_ENVELOPE_STEP:   env_step_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			index_q       <= '0;
			env_q         <= '0;
			tone_active_q <= 1'b0;
		end else if (cmd.accept) begin
			tone_active_q <= play && !fin;
			if (play) begin
				phase_q <= phase_sum[PHASE_BITS-1:0];
				index_q <= index_inc[LB-1:0];
				env_q   <= (env_eff > env_step_q) ? (env_eff - env_step_q) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			j_s1   <= j_next;
			neg_s1 <= addr[LOG2N-1];
			env_s1 <= env_eff;
		end
		if (cmd.read) begin
			mag_s2 <= qrom[j_s1];
		end
		if (cmd.mul1) begin
			prod_s3 <= 30'(mag_s2) * 30'(volume_q);
		end
		if (cmd.load_out) begin
			sample_q <= !act_s1 ? '0 : (neg_s1 ? -$signed(mag_out) : $signed(mag_out));
			active_q <= act_s1;
			last_q   <= fin_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			fin_s1 <= 1'b0;
		end else if (cmd.accept) begin
			act_s1 <= play;
			fin_s1 <= play && fin;
		end
	end

	assign sample = sample_q;
	assign active = active_q;
	assign last   = last_q;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the decaying sine tone generator core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dstg_pkg::*;

	localparam int unsigned     SINE_DEPTH     = 1024;
	localparam longint unsigned Q30_ONE        = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;
	localparam int unsigned     RANDOM_ITEMS   = 1050;
	localparam int unsigned     SETTLE_CYCLES  = 8;
	localparam int unsigned     WATCHDOG_LIMIT = 2000;

	// An index that maps to no register; writes to it must be ignored.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum int unsigned {
		STALL_NONE,
		STALL_RANDOM,
		STALL_BURSTS
	} stall_mode_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               active;
		logic               last;
	} tone_sample_t;

	// Every input of the block starts at a known value.
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic                   start_req = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic signed [15:0]     sample;
	logic                   active;
	logic                   last;

	decaying_sine_tone_generator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.start_req (start_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.active    (active),
		.last      (last)
	);

	// Our own view of the configuration registers, updated as they are written.
	logic        cfg_enabled   = RST_ENABLED;
	logic [30:0] cfg_phase_inc = RST_PHASE_INCREMENT;
	logic [15:0] cfg_tone_len  = RST_TONE_LENGTH;
	logic [14:0] cfg_volume    = RST_VOLUME_GAIN;
	logic [16:0] cfg_env_step  = RST_ENVELOPE_STEP;

	// Tone state of the predictor, cleared as the block's reset clears it.
	logic [31:0] tone_phase = '0;
	logic [15:0] tone_index = '0;
	logic [16:0] tone_env   = '0;
	logic        tone_on    = 1'b0;

	// Q15 sine table, built once at time zero with the same integer series
	// and quadrant folding that the block's constant table was made with.
	int sine_q15 [SINE_DEPTH];

	tone_sample_t expected_samples [$];

	int unsigned err_count  = 0;
	int unsigned burst_left = 0;

	// The clock runs free from time zero.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the sample that one accepted request must produce, and move
	// the predictor's tone state along exactly as the block does.
	task automatic predict_tone_sample(input logic start_bit);
		tone_sample_t    want;
		logic [9:0]      addr;
		int              tbl;
		longint unsigned mag;
		logic [15:0]     mag16;

		want = '0;
		if (!cfg_enabled) begin
			// Disabling silences the generator and drops any tone in progress.
			tone_on = 1'b0;
		end else begin
			// A start, even in the middle of a tone, begins a fresh tone here.
			if (start_bit) begin
				tone_on    = 1'b1;
				tone_phase = '0;
				tone_index = '0;
				tone_env   = ENV_ONE;
			end
			if (tone_on) begin
				// The table address is the top ten bits of the phase.
				addr = tone_phase[31:22];
				tbl  = sine_q15[addr];
				mag  = 64'((tbl < 0) ? -tbl : tbl);
				// Magnitude times Q15 gain times Q16 envelope, then truncated:
				// working on the magnitude makes the result round toward zero.
				mag   = (mag * cfg_volume * tone_env) >> 31;
				mag16 = mag[15:0];
				want.sample = (tbl < 0) ? -$signed(mag16) : $signed(mag16);
				want.active = 1'b1;
				// A length of zero makes the very first sample the last one.
				want.last = (({16'd0, tone_index} + 32'd1) >= {16'd0, cfg_tone_len});
				tone_phase = tone_phase + {1'b0, cfg_phase_inc};
				tone_index = tone_index + 16'd1;
				// The envelope stops at zero when the step overshoots it.
				tone_env = (tone_env > cfg_env_step) ? tone_env - cfg_env_step : '0;
				if (want.last) begin
					tone_on = 1'b0;
				end
			end
		end
		expected_samples.push_back(want);
	endtask

	// Present one sample request and hold it until the block takes it. The
	// sender runs in bursts: once a burst is used up, it may go quiet before
	// the next one starts.
	task automatic send_request(input logic start_bit);
		int unsigned gap;

		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid  <= 1'b1;
		start_req <= start_bit;
		do @(posedge clk); while (!in_ready);
		// The request was taken at this edge.
		predict_tone_sample(start_bit);
		burst_left--;
	endtask

	// Stop sending and let every outstanding request come back, then let
	// the pipeline settle so the block is surely idle.
	task automatic wait_until_drained;
		in_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write, followed by a pause with the write enable low so that
	// back-to-back writes never lower and raise the write enable at the same edge.
	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		// Each register keeps only the bits of its own width.
		case (index)
			REG_ENABLED:         cfg_enabled   = value[0];
			REG_PHASE_INCREMENT: cfg_phase_inc = value[30:0];
			REG_TONE_LENGTH:     cfg_tone_len  = value[15:0];
			REG_VOLUME_GAIN:     cfg_volume    = value[14:0];
			REG_ENVELOPE_STEP:   cfg_env_step  = value[16:0];
			default: ;
		endcase
	endtask

	// The reset values alone: an idle tick gives silence, then a default tone.
	task automatic test_reset_defaults;
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
		wait_until_drained;
	endtask

	// Extremes of the phase, volume and envelope registers: full-scale peaks of both signs, the largest
	// phase step, zero volume, and envelope steps that empty the envelope at
	// once or overshoot it.
	task automatic test_register_extremes;
		write_register(REG_PHASE_INCREMENT, 31'h4000_0000);
		write_register(REG_VOLUME_GAIN, 31'd32767);
		write_register(REG_ENVELOPE_STEP, 31'd0);
		write_register(REG_TONE_LENGTH, 31'd4);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b0);
		wait_until_drained;

		write_register(REG_PHASE_INCREMENT, 31'h7FFF_FFFF);
		write_register(REG_VOLUME_GAIN, 31'd0);
		send_request(1'b1);
		send_request(1'b0);
		wait_until_drained;

		write_register(REG_VOLUME_GAIN, 31'd32767);
		write_register(REG_ENVELOPE_STEP, 31'd65536);
		send_request(1'b1);
		send_request(1'b0);
		wait_until_drained;

		write_register(REG_ENVELOPE_STEP, 31'h1FFFF);
		send_request(1'b1);
		send_request(1'b0);
		wait_until_drained;
	endtask

	// Single-sample tones, and a zero length that behaves as one sample.
	task automatic test_short_tones;
		write_register(REG_PHASE_INCREMENT, 31'd77906381);
		write_register(REG_ENVELOPE_STEP, 31'd19);
		write_register(REG_TONE_LENGTH, 31'd1);
		send_request(1'b1);
		send_request(1'b1);
		send_request(1'b0);
		wait_until_drained;

		write_register(REG_TONE_LENGTH, 31'd0);
		send_request(1'b1);
		send_request(1'b0);
		wait_until_drained;
	endtask

	// A start in the middle of a tone must restart phase, count and envelope.
	task automatic test_restart;
		write_register(REG_TONE_LENGTH, 31'd6);
		write_register(REG_ENVELOPE_STEP, 31'd10923);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
		wait_until_drained;
	endtask

	// Disabled ticks are silent and ignore starts; a write to an unused
	// index changes nothing.
	task automatic test_disabled;
		write_register(REG_ENABLED, 31'd0);
		send_request(1'b1);
		send_request(1'b0);
		wait_until_drained;

		write_register(REG_UNUSED, '1);
		write_register(REG_ENABLED, 31'd1);
		send_request(1'b0);
		send_request(1'b1);
		wait_until_drained;
	endtask

	// Random phases: each one draws a new configuration, with junk above the width of every register
	// but the phase increment half of the time, then plays a run of requests.
	task automatic test_random_tones;
		int unsigned sent;
		int unsigned count;
		logic [31:0] junk;
		logic [15:0] len;
		logic [16:0] step;
		logic        well_formed;
		logic        start_bit;

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_until_drained;

			junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
			write_register(REG_ENABLED, CFG_DATA_W'({junk, ($urandom_range(0, 9) != 0)}));

			if ($urandom_range(0, 3) == 0) begin
				write_register(REG_PHASE_INCREMENT, CFG_DATA_W'($urandom_range(0, 32'hFF_FFFF)));
			end else begin
				write_register(REG_PHASE_INCREMENT, CFG_DATA_W'($urandom()));
			end

			// Mostly short tones so that many of them run to their end.
			case ($urandom_range(0, 9))
				0:       len = 16'($urandom_range(0, 1));
				1:       len = 16'($urandom_range(100, 65535));
				2:       len = 16'hFFFF;
				default: len = 16'($urandom_range(2, 40));
			endcase
			junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
			write_register(REG_TONE_LENGTH, CFG_DATA_W'({junk, len}));

			junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
			case ($urandom_range(0, 5))
				0:       write_register(REG_VOLUME_GAIN, CFG_DATA_W'({junk, 15'd0}));
				1:       write_register(REG_VOLUME_GAIN, CFG_DATA_W'({junk, 15'd32767}));
				default: write_register(REG_VOLUME_GAIN, CFG_DATA_W'({junk, 15'($urandom())}));
			endcase

			// Usually the step that brings the envelope down over the tone.
			if (($urandom_range(0, 3) == 0) || (len == 16'd0)) begin
				step = 17'($urandom());
			end else begin
				step = 17'(32'd65536 / len);
			end
			junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
			write_register(REG_ENVELOPE_STEP, CFG_DATA_W'({junk, step}));

			// Most phases are orderly: a start, the tone to its end, a pause,
			// with the odd restart. The rest fire starts at random.
			well_formed = ($urandom_range(0, 4) != 0);
			count = $urandom_range(30, 120);
			repeat (count) begin
				if (well_formed) begin
					start_bit = tone_on ? ($urandom_range(0, 99) < 2)
						: ($urandom_range(0, 99) < 40);
				end else begin
					start_bit = ($urandom_range(0, 99) < 30);
				end
				send_request(start_bit);
				sent++;
				// Now and then the sender holds off until everything is back.
				if ($urandom_range(0, 199) == 0) begin
					wait_until_drained;
				end
			end
		end
	endtask

	// The receiver stalls on its own schedule: stretches of no stalling,
	// random stalls, and long stall bursts.
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned mode_left  = 0;
	int unsigned hold_left  = 0;
	logic        hold_ready = 1'b1;

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			mode_left  = $urandom_range(50, 300);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			STALL_NONE: begin
				out_ready <= 1'b1;
			end
			STALL_RANDOM: begin
				out_ready <= ($urandom_range(0, 9) < 7);
			end
			default: begin
				if (hold_left == 0) begin
					hold_ready = ~hold_ready;
					hold_left  = hold_ready ? $urandom_range(1, 10) : $urandom_range(1, 30);
				end else begin
					hold_left--;
				end
				out_ready <= hold_ready;
			end
		endcase
	end

	// Each sample handed over is compared with the oldest prediction.
	always @(posedge clk) begin : check_results
		tone_sample_t want;

		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, expected none, actual sample %0d",
					$time, sample);
			end else begin
				want = expected_samples.pop_front();
				if (sample !== want.sample) begin
					err_count++;
					$display("%0t: sample mismatch, expected %0d, actual %0d",
						$time, $signed(want.sample), sample);
				end
				if (active !== want.active) begin
					err_count++;
					$display("%0t: active mismatch, expected %0b, actual %0b",
						$time, want.active, active);
				end
				if (last !== want.last) begin
					err_count++;
					$display("%0t: last mismatch, expected %0b, actual %0b",
						$time, want.last, last);
				end
			end
		end
	end

	// A run that stops moving in either direction for too long has hung.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : main_sequence
		longint unsigned a, q, r, num, x, x2, t, s, mag;

		// Quarter-wave folding: the second and fourth quarters run the angle
		// backward, the second half takes the negative sign.
		for (int k = 0; k < SINE_DEPTH; k++) begin
			a   = 64'(4 * k);
			q   = a / SINE_DEPTH;
			r   = a % SINE_DEPTH;
			num = q[0] ? (SINE_DEPTH - r) : r;
			x   = (num * HALF_PI_Q30) / SINE_DEPTH;
			// Horner form of the Taylor series of sin up to x^11, in Q30.
			x2  = (x * x) >> 30;
			t   = Q30_ONE - x2 / 110;
			t   = Q30_ONE - ((x2 * t) >> 30) / 72;
			t   = Q30_ONE - ((x2 * t) >> 30) / 42;
			t   = Q30_ONE - ((x2 * t) >> 30) / 20;
			t   = Q30_ONE - ((x2 * t) >> 30) / 6;
			s   = (x * t) >> 30;
			mag = (s * 32767 + (Q30_ONE >> 1)) >> 30;
			if (mag > 32767) begin
				mag = 32767;
			end
			sine_q15[k] = (q >= 2) ? -int'(mag) : int'(mag);
		end

		// Reset is held at the start and released once.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults;
		test_register_extremes;
		test_short_tones;
		test_restart;
		test_disabled;
		test_random_tones;

		wait_until_drained;
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dstg_pkg.sv
rtl/dstg_ctrl.sv
rtl/dstg_datapath.sv
rtl/decaying_sine_tone_generator_core.sv
dv/tb_top.sv
